/* sv/ascii_decimal_alu_unit_defines.svh */
// assertion macros used by the top rtl file
`ifndef ASCII_DECIMAL_ALU_UNIT_DEFINES_SVH
`define ASCII_DECIMAL_ALU_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked on every rising clock edge outside reset
`define ADAU_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("adau assertion failed");

// condition that must never hold outside reset
`define ADAU_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("adau forbidden condition seen");

`else

`define ADAU_ASSERT(lbl, clk, rstn, prop)
`define ADAU_NEVER(lbl, clk, rstn, cond)

`endif

`endif

/* sv/adau_pkg.sv */
package adau_pkg;

	localparam int N_CHARS = 32;
	localparam int N_WORDS = 4;
	localparam int LOG_CHARS = $clog2(N_CHARS);

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [2:0] {
		CMD_ADD  = 3'd0,
		CMD_SUB  = 3'd1,
		CMD_LESS = 3'd2,
		CMD_ZERO = 3'd3,
		CMD_INC  = 3'd4
	} cmd_t;

	// what one digit lane hands to the merge stage
	typedef struct packed {
		logic       act;
		logic [3:0] dig0;
		logic [3:0] dig1;
		logic       gen;
		logic       prop;
		logic       bad;
		logic       ne;
		logic       lt;
		logic       nz;
	} lane_t;

	// result flags of one request
	typedef struct packed {
		logic less;
		logic zero;
		logic carry;
		logic bad;
	} flags_t;

endpackage

/* sv/adau_lane.sv */
module adau_lane import adau_pkg::*; (
	input  logic [7:0] a_char,
	input  logic [7:0] b_char,
	input  logic [2:0] command,
	input  logic       active,
	output lane_t      info
);

	logic       is_inc;
	logic       is_sub;
	logic       arith;
	logic       a_dig;
	logic       b_dig;
	logic [4:0] da;
	logic [4:0] db;
	logic [4:0] sum;
	logic [4:0] diff;
	logic [4:0] wrap;
	logic       sub_gen;
	logic       sub_prop;

	// command decode
	assign is_inc = (command == CMD_INC);
	assign is_sub = (command == CMD_SUB);
	assign arith  = (command == CMD_ADD) || is_sub || is_inc;

	// digit checks
	assign a_dig = (a_char >= CH_ZERO) && (a_char <= CH_NINE);
	assign b_dig = (b_char >= CH_ZERO) && (b_char <= CH_NINE);

	// digit values, b is zero for increment
	assign da   = {1'b0, a_char[3:0]};
	assign db   = is_inc ? 5'd0 : {1'b0, b_char[3:0]};
	assign sum  = da + db;
	assign diff = da - db;
	assign wrap = da + 5'd10 - db;

	assign sub_gen  = (da < db);
	assign sub_prop = (da == db);

	// digit for both carry-in values plus generate and propagate
	always_comb begin
		info = '0;
		info.act = active;
		if (is_sub) begin
			info.gen  = sub_gen;
			info.prop = sub_prop;
			info.dig0 = sub_gen ? wrap[3:0] : diff[3:0];
			info.dig1 = (sub_gen || sub_prop) ? 4'(wrap - 5'd1) : 4'(diff - 5'd1);
		end else begin
			info.gen  = (sum > 5'd9);
			info.prop = (sum == 5'd9);
			info.dig0 = (sum > 5'd9) ? 4'(sum - 5'd10) : sum[3:0];
			info.dig1 = (sum >= 5'd9) ? 4'(sum - 5'd9) : 4'(sum + 5'd1);
		end
		info.bad = active && arith && (!a_dig || (!is_inc && !b_dig));
		info.ne  = active && (a_char != b_char);
		info.lt  = (a_char < b_char);
		info.nz  = active && (a_char != CH_ZERO);
		// an idle lane passes the carry straight through
		if (!active) begin
			info.gen  = 1'b0;
			info.prop = 1'b1;
		end
	end

endmodule

/* sv/adau_merge.sv */
module adau_merge import adau_pkg::*; (
	input  logic                        [2:0]  command,
	input  lane_t                              lanes [N_CHARS],
	output logic [N_WORDS-1:0][63:0]           result,
	output flags_t                             flags
);

	logic              is_inc;
	logic              arith;
	logic              cin;
	logic              any_bad;
	logic              any_nz;
	logic              ok;
	logic              cmp_lt;
	logic [N_CHARS-1:0] cout;
	logic [N_CHARS-1:0] cin_lane;

	assign is_inc = (command == CMD_INC);
	assign arith  = (command == CMD_ADD) || (command == CMD_SUB) || is_inc;
	assign cin    = is_inc;

	// carry prefix tree, position 0 is the last character
	always_comb begin
		logic [N_CHARS-1:0] g;
		logic [N_CHARS-1:0] p;
		for (int k = 0; k < N_CHARS; k++) begin
			g[k] = lanes[N_CHARS-1-k].gen;
			p[k] = lanes[N_CHARS-1-k].prop;
		end
		for (int d = 0; d < LOG_CHARS; d++) begin
			for (int j = N_CHARS - 1; j >= (1 << d); j--) begin
				g[j] = g[j] | (p[j] & g[j - (1 << d)]);
				p[j] = p[j] & p[j - (1 << d)];
			end
		end
		for (int k = 0; k < N_CHARS; k++) begin
			cout[k] = g[k] | (p[k] & cin);
		end
		for (int k = 0; k < N_CHARS; k++) begin
			cin_lane[N_CHARS-1-k] = (k == 0) ? cin : cout[k-1];
		end
	end

	// reductions over the lanes
	always_comb begin
		any_bad = 1'b0;
		any_nz  = 1'b0;
		for (int i = 0; i < N_CHARS; i++) begin
			any_bad = any_bad | lanes[i].bad;
			any_nz  = any_nz | lanes[i].nz;
		end
	end

	// first differing character wins, character 0 first
	always_comb begin
		logic [N_CHARS-1:0] fnd;
		logic [N_CHARS-1:0] ltv;
		for (int i = 0; i < N_CHARS; i++) begin
			fnd[i] = lanes[i].ne;
			ltv[i] = lanes[i].lt;
		end
		for (int d = 0; d < LOG_CHARS; d++) begin
			for (int j = 0; j < (N_CHARS >> (d + 1)); j++) begin
				ltv[j] = fnd[2*j] ? ltv[2*j] : ltv[2*j+1];
				fnd[j] = fnd[2*j] | fnd[2*j+1];
			end
		end
		cmp_lt = fnd[0] & ltv[0];
	end

	assign ok = arith && !any_bad;

	// digit select and packing
	always_comb begin
		logic [3:0] dig;
		result = '0;
		for (int i = 0; i < N_CHARS; i++) begin
			dig = cin_lane[i] ? lanes[i].dig1 : lanes[i].dig0;
			if (ok && lanes[i].act) begin
				result[i >> 3][(7 - (i & 7)) * 8 +: 8] = {CH_ZERO[7:4], dig};
			end
		end
	end

	// flags
	always_comb begin
		flags       = '0;
		flags.bad   = arith && any_bad;
		flags.carry = ok && cout[N_CHARS-1];
		flags.less  = (command == CMD_LESS) && cmp_lt;
		flags.zero  = (command == CMD_ZERO) && !any_nz;
	end

endmodule

/* sv/ascii_decimal_alu_unit.sv */
// ascii decimal alu: add, subtract, compare, zero test and increment on
// numbers of up to 32 ascii digits, most significant character first.
// request channel: in_valid, in_stall, command and the eight operand words.
// result channel: out_valid, out_stall, the four result words and flags.
// a request is taken at a clock edge with valid high and stall low.
// a taken request goes into the lane register, fed by the digit lanes,
// then into the output register, fed by the merge stage (carry prefix
// tree over the 32 lanes and first-difference compare tree); the output
// register drives out_valid. throughput: one request per cycle, sustained
// while the receiver takes results; the carry tree settles in the merge stage.
// when out_stall is high the output register holds its result, the lane
// register fills, and in_stall rises once both are occupied.
// reset (arst_n low) empties both stages; no request in flight survives.
// DIGITS sets how many leading characters are used; the rest read as zero
// bytes in the result and are ignored by every command.
`include "ascii_decimal_alu_unit_defines.svh"

module ascii_decimal_alu_unit import adau_pkg::*; #(
	parameter int DIGITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [63:0] a_word0,
	input  logic [63:0] a_word1,
	input  logic [63:0] a_word2,
	input  logic [63:0] a_word3,
	input  logic [63:0] b_word0,
	input  logic [63:0] b_word1,
	input  logic [63:0] b_word2,
	input  logic [63:0] b_word3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_word0,
	output logic [63:0] result_word1,
	output logic [63:0] result_word2,
	output logic [63:0] result_word3,
	output logic        less,
	output logic        zero,
	output logic        carry_out,
	output logic        bad_digit
);

	localparam int NDIG = (DIGITS > N_CHARS) ? N_CHARS : ((DIGITS < 1) ? 1 : DIGITS);

	logic [N_WORDS-1:0][63:0] a_words;
	logic [N_WORDS-1:0][63:0] b_words;
	lane_t                    lane_info [N_CHARS];
	lane_t                    lane_s1 [N_CHARS];
	logic [2:0]               cmd_s1;
	logic                     valid_s1;
	logic [N_WORDS-1:0][63:0] merge_result;
	flags_t                   merge_flags;
	logic [N_WORDS-1:0][63:0] result_q;
	flags_t                   flags_q;
	logic                     out_valid_q;
	logic                     en_s1;
	logic                     en_s2;

	assign a_words = {a_word3, a_word2, a_word1, a_word0};
	assign b_words = {b_word3, b_word2, b_word1, b_word0};

	// one lane per character
	for (genvar i = 0; i < N_CHARS; i++) begin : g_lane
		adau_lane u_lane (
			.a_char  (a_words[i >> 3][(7 - (i & 7)) * 8 +: 8]),
			.b_char  (b_words[i >> 3][(7 - (i & 7)) * 8 +: 8]),
			.command (command),
			.active  (i < NDIG),
			.info    (lane_info[i])
		);
	end

	// stage enables
	assign en_s2    = !out_valid_q || !out_stall;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// lane register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			cmd_s1  <= command;
			lane_s1 <= lane_info;
		end
	end

	// carry and compare merge
	adau_merge u_merge (
		.command (cmd_s1),
		.lanes   (lane_s1),
		.result  (merge_result),
		.flags   (merge_flags)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_s2) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			result_q <= merge_result;
			flags_q  <= merge_flags;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_word0 = result_q[0];
	assign result_word1 = result_q[1];
	assign result_word2 = result_q[2];
	assign result_word3 = result_q[3];
	assign less         = flags_q.less;
	assign zero         = flags_q.zero;
	assign carry_out    = flags_q.carry;
	assign bad_digit    = flags_q.bad;

	// checks
	`ADAU_ASSERT(a_stall_only_full, clk, arst_n, in_stall |-> (valid_s1 && out_valid_q && out_stall))
	`ADAU_ASSERT(a_take_fills_s1, clk, arst_n, (in_valid && !in_stall) |=> valid_s1)
	`ADAU_ASSERT(a_bad_clears, clk, arst_n, (out_valid_q && bad_digit) |-> (result_q == '0 && !carry_out))
	`ADAU_NEVER(n_flag_mix, clk, arst_n, out_valid_q && ((less && zero) || (carry_out && (less || zero))))

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import adau_pkg::*;

	localparam int DIGITS = 32;
	localparam int N_ACTIVE = (DIGITS > N_CHARS) ? N_CHARS : ((DIGITS < 1) ? 1 : DIGITS);
	localparam int RAND_PER_PHASE = 350;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_LIMIT = 20000;

	// command codes the block treats as no-ops
	localparam logic [2:0] CMD_RSVD5 = 3'd5;
	localparam logic [2:0] CMD_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_RSVD7 = 3'd7;

	localparam logic [255:0] TXT_ZERO = {N_CHARS{CH_ZERO}};
	localparam logic [255:0] TXT_NINE = {N_CHARS{CH_NINE}};
	localparam logic [255:0] TXT_ONE = {{(N_CHARS - 1){CH_ZERO}}, CH_ZERO + 8'd1};
	localparam logic [255:0] TXT_MAX_SUM = {{(N_CHARS - 1){CH_NINE}}, CH_ZERO + 8'd8};
	localparam logic [255:0] SAMPLE_A = "12345678901234567890123456789012";
	localparam logic [255:0] SAMPLE_B = "98765432109876543210987654321098";

	typedef struct packed {
		logic [2:0]   cmd;
		logic [255:0] a;
		logic [255:0] b;
	} alu_request_t;

	typedef struct packed {
		logic [255:0] text;
		logic         less;
		logic         zero;
		logic         carry;
		logic         bad;
	} alu_result_t;

	typedef struct packed {
		alu_request_t rq;
		logic         known;
		alu_result_t  res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  command = 3'd0;
	logic [63:0] a_word0 = '0;
	logic [63:0] a_word1 = '0;
	logic [63:0] a_word2 = '0;
	logic [63:0] a_word3 = '0;
	logic [63:0] b_word0 = '0;
	logic [63:0] b_word1 = '0;
	logic [63:0] b_word2 = '0;
	logic [63:0] b_word3 = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] result_word0;
	logic [63:0] result_word1;
	logic [63:0] result_word2;
	logic [63:0] result_word3;
	logic        less;
	logic        zero;
	logic        carry_out;
	logic        bad_digit;

	alu_result_t pending_results[$];
	dir_row_t    directed[$];

	int idle_pct = 0;
	int stall_pct = 0;
	logic long_hold = 1'b0;
	logic pressure_go = 1'b0;

	int fault_count = 0;
	int results_checked = 0;
	int requests_sent = 0;
	int held_off_cycles = 0;
	int carry_seen = 0;
	int bad_seen = 0;

	ascii_decimal_alu_unit #(
		.DIGITS(DIGITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.a_word0(a_word0),
		.a_word1(a_word1),
		.a_word2(a_word2),
		.a_word3(a_word3),
		.b_word0(b_word0),
		.b_word1(b_word1),
		.b_word2(b_word2),
		.b_word3(b_word3),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_word0(result_word0),
		.result_word1(result_word1),
		.result_word2(result_word2),
		.result_word3(result_word3),
		.less(less),
		.zero(zero),
		.carry_out(carry_out),
		.bad_digit(bad_digit)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] char_at(input logic [255:0] v, input int i);
		return v[255 - 8 * i -: 8];
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// expected outcome of one decimal alu request
	function automatic alu_result_t predict_alu(input alu_request_t rq);
		alu_result_t res;
		logic arith;
		logic found;
		int da;
		int db;
		int sub;
		int val;
		int cy;
		res = '0;
		arith = (rq.cmd == CMD_ADD) || (rq.cmd == CMD_SUB) || (rq.cmd == CMD_INC);
		// digit check over the operands the command reads
		if (arith) begin
			for (int i = 0; i < N_ACTIVE; i++) begin
				if (!is_digit(char_at(rq.a, i)))
					res.bad = 1'b1;
				if (rq.cmd != CMD_INC && !is_digit(char_at(rq.b, i)))
					res.bad = 1'b1;
			end
		end
		if (arith && !res.bad) begin
			// ripple from the least significant character upward
			cy = (rq.cmd == CMD_INC) ? 1 : 0;
			for (int i = N_ACTIVE - 1; i >= 0; i--) begin
				da = int'(char_at(rq.a, i)) - int'(CH_ZERO);
				db = int'(char_at(rq.b, i)) - int'(CH_ZERO);
				if (rq.cmd == CMD_SUB) begin
					sub = db + cy;
					if (da < sub) begin
						cy = 1;
						da = da + 10;
					end else begin
						cy = 0;
					end
					val = da - sub;
				end else begin
					val = da + cy + ((rq.cmd == CMD_ADD) ? db : 0);
					if (val > 9) begin
						cy = 1;
						val = val - 10;
					end else begin
						cy = 0;
					end
				end
				res.text[255 - 8 * i -: 8] = CH_ZERO + val[7:0];
			end
			res.carry = (cy != 0);
		end else if (rq.cmd == CMD_LESS) begin
			// first differing byte decides
			found = 1'b0;
			for (int i = 0; i < N_ACTIVE; i++) begin
				if (!found && char_at(rq.a, i) != char_at(rq.b, i)) begin
					res.less = char_at(rq.a, i) < char_at(rq.b, i);
					found = 1'b1;
				end
			end
		end else if (rq.cmd == CMD_ZERO) begin
			res.zero = 1'b1;
			for (int i = 0; i < N_ACTIVE; i++)
				if (char_at(rq.a, i) != CH_ZERO)
					res.zero = 1'b0;
		end
		return res;
	endfunction

	function automatic logic [255:0] rand_digits();
		logic [255:0] v;
		for (int i = 0; i < N_CHARS; i++)
			v[255 - 8 * i -: 8] = CH_ZERO + 8'($urandom_range(9));
		return v;
	endfunction

	// operand mix: mostly clean numbers, some carry runs, some garbage
	function automatic logic [255:0] rand_operand();
		logic [255:0] v;
		int kind;
		int cut;
		kind = $urandom_range(99);
		cut = $urandom_range(N_CHARS);
		v = rand_digits();
		if (kind < 12) begin
			for (int i = 0; i < N_CHARS; i++)
				if (i >= cut)
					v[255 - 8 * i -: 8] = CH_NINE;
		end else if (kind < 20) begin
			for (int i = 0; i < N_CHARS; i++)
				if (i < cut)
					v[255 - 8 * i -: 8] = CH_ZERO;
		end else if (kind < 28) begin
			v[255 - 8 * (cut % N_CHARS) -: 8] = 8'($urandom_range(255));
		end else if (kind < 34) begin
			for (int k = 0; k < 8; k++)
				v[32 * k +: 32] = $urandom;
		end
		return v;
	endfunction

	function automatic alu_request_t rand_request();
		alu_request_t rq;
		int pick;
		int pos;
		pick = $urandom_range(99);
		pos = $urandom_range(N_CHARS - 1);
		if (pick < 22)
			rq.cmd = CMD_ADD;
		else if (pick < 44)
			rq.cmd = CMD_SUB;
		else if (pick < 62)
			rq.cmd = CMD_LESS;
		else if (pick < 74)
			rq.cmd = CMD_ZERO;
		else if (pick < 94)
			rq.cmd = CMD_INC;
		else
			rq.cmd = CMD_RSVD5 + 3'($urandom_range(2));
		rq.a = rand_operand();
		rq.b = rand_operand();
		// compare: equal operands or a single difference at a random position
		if (rq.cmd == CMD_LESS && $urandom_range(1)) begin
			rq.b = rq.a;
			if ($urandom_range(1))
				rq.b[255 - 8 * pos -: 8] = 8'($urandom_range(255));
		end
		// zero test: near-zero operands
		if (rq.cmd == CMD_ZERO && $urandom_range(1)) begin
			rq.a = TXT_ZERO;
			if ($urandom_range(1))
				rq.a[255 - 8 * pos -: 8] = 8'($urandom_range(255));
		end
		return rq;
	endfunction

	function automatic void add_row(input logic [2:0] cmd, input logic [255:0] a,
		input logic [255:0] b, input logic known, input logic [255:0] text,
		input int lt, input int zr, input int cy, input int bd);
		dir_row_t r;
		r.rq.cmd = cmd;
		r.rq.a = a;
		r.rq.b = b;
		r.known = known;
		r.res.text = text;
		r.res.less = (lt != 0);
		r.res.zero = (zr != 0);
		r.res.carry = (cy != 0);
		r.res.bad = (bd != 0);
		directed.push_back(r);
	endfunction

	function automatic void log_fault(input string what, input logic [255:0] want,
		input logic [255:0] got);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch in %s: expected %h, got %h", what, want, got);
	endfunction

	// offer one request, hold it until taken, then queue its expected result
	task automatic issue_request(input alu_request_t rq, input alu_result_t want);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= rq.cmd;
		{a_word0, a_word1, a_word2, a_word3} <= rq.a;
		{b_word0, b_word1, b_word2, b_word3} <= rq.b;
		@(posedge clk);
		while (in_stall) begin
			held_off_cycles++;
			@(posedge clk);
		end
		pending_results.push_back(want);
		requests_sent++;
	endtask

	task automatic check_result();
		alu_result_t want;
		logic [255:0] got_text;
		if (pending_results.size() == 0) begin
			log_fault("result with no request waiting", '0, '0);
			return;
		end
		want = pending_results.pop_front();
		got_text = {result_word0, result_word1, result_word2, result_word3};
		results_checked++;
		if (want.carry)
			carry_seen++;
		if (want.bad)
			bad_seen++;
		if (got_text !== want.text)
			log_fault("result words", want.text, got_text);
		if (less !== want.less)
			log_fault("less", 256'(want.less), 256'(less));
		if (zero !== want.zero)
			log_fault("zero", 256'(want.zero), 256'(zero));
		if (carry_out !== want.carry)
			log_fault("carry_out", 256'(want.carry), 256'(carry_out));
		if (bad_digit !== want.bad)
			log_fault("bad_digit", 256'(want.bad), 256'(bad_digit));
	endtask

	// result side: check taken results, pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
		out_stall <= long_hold || ($urandom_range(99) < stall_pct);
	end

	// long receiver hold-off so the block backs up into the request side
	initial begin
		wait (pressure_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// run time limit
	initial begin
		#5000000;
		$display("ascii_decimal_alu_unit regression: fail");
		$finish;
	end

	// stimulus
	initial begin
		alu_request_t rq;
		int guard;
		arst_n = 1'b0;

		// directed rows: extremes, every command, error cases
		add_row(CMD_ADD, TXT_ZERO, TXT_ZERO, 1'b1, TXT_ZERO, 0, 0, 0, 0);
		add_row(CMD_ADD, TXT_NINE, TXT_ONE, 1'b1, TXT_ZERO, 0, 0, 1, 0);
		add_row(CMD_ADD, TXT_NINE, TXT_NINE, 1'b1, TXT_MAX_SUM, 0, 0, 1, 0);
		add_row(CMD_SUB, TXT_ZERO, TXT_ONE, 1'b1, TXT_NINE, 0, 0, 1, 0);
		add_row(CMD_SUB, TXT_NINE, TXT_NINE, 1'b1, TXT_ZERO, 0, 0, 0, 0);
		add_row(CMD_SUB, SAMPLE_A, SAMPLE_B, 1'b0, '0, 0, 0, 0, 0);
		add_row(CMD_ADD, SAMPLE_A, SAMPLE_B, 1'b0, '0, 0, 0, 0, 0);
		add_row(CMD_INC, TXT_NINE, '1, 1'b1, TXT_ZERO, 0, 0, 1, 0);
		add_row(CMD_INC, TXT_ZERO, '1, 1'b1, TXT_ONE, 0, 0, 0, 0);
		add_row(CMD_INC, SAMPLE_A, '0, 1'b0, '0, 0, 0, 0, 0);
		add_row(CMD_LESS, SAMPLE_A, SAMPLE_A, 1'b1, '0, 0, 0, 0, 0);
		add_row(CMD_LESS, TXT_ZERO, TXT_ONE, 1'b1, '0, 1, 0, 0, 0);
		add_row(CMD_LESS, TXT_ONE, TXT_ZERO, 1'b1, '0, 0, 0, 0, 0);
		add_row(CMD_LESS, '0, '1, 1'b1, '0, 1, 0, 0, 0);
		add_row(CMD_LESS, '1, '0, 1'b1, '0, 0, 0, 0, 0);
		add_row(CMD_ZERO, TXT_ZERO, '1, 1'b1, '0, 0, 1, 0, 0);
		add_row(CMD_ZERO, TXT_ONE, TXT_ZERO, 1'b1, '0, 0, 0, 0, 0);
		add_row(CMD_ZERO, '0, TXT_ZERO, 1'b1, '0, 0, 0, 0, 0);
		add_row(CMD_ADD, {8'h2F, {(N_CHARS - 1){CH_ZERO}}}, TXT_ZERO, 1'b1, '0, 0, 0, 0, 1);
		add_row(CMD_ADD, TXT_ZERO, {{(N_CHARS - 1){CH_ZERO}}, 8'h3A}, 1'b1, '0, 0, 0, 0, 1);
		add_row(CMD_SUB, TXT_ZERO, '1, 1'b1, '0, 0, 0, 0, 1);
		add_row(CMD_INC, {{(N_CHARS - 1){CH_ZERO}}, 8'h00}, TXT_ZERO, 1'b1, '0, 0, 0, 0, 1);
		add_row(CMD_RSVD5, SAMPLE_A, SAMPLE_B, 1'b1, '0, 0, 0, 0, 0);
		add_row(CMD_RSVD6, '1, '1, 1'b1, '0, 0, 0, 0, 0);
		add_row(CMD_RSVD7, TXT_NINE, TXT_ZERO, 1'b1, '0, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under light idling on both sides
		idle_pct = 12;
		stall_pct <= 12;
		foreach (directed[i])
			issue_request(directed[i].rq,
				directed[i].known ? directed[i].res : predict_alu(directed[i].rq));

		// random part over the handshake phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct = 86;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 86;
				end
				default: begin
					idle_pct = 12;
					stall_pct <= 12;
				end
			endcase
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				if (ph == 0 && n == 100)
					pressure_go <= 1'b1;
				rq = rand_request();
				issue_request(rq, predict_alu(rq));
			end
		end

		// drain outstanding results
		in_valid <= 1'b0;
		stall_pct <= 0;
		guard = 0;
		while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			fault_count += pending_results.size();
			$display("%0d expected results never arrived", pending_results.size());
		end

		$display("sent %0d requests (%0d directed), checked %0d results,",
			requests_sent, directed.size(), results_checked);
		$display("%0d with carry or borrow, %0d with bad digits", carry_seen, bad_seen);
		$display("request side held off for %0d cycles; %0d faults", held_off_cycles, fault_count);
		if (fault_count == 0)
			$display("ascii_decimal_alu_unit regression: pass");
		else
			$display("ascii_decimal_alu_unit regression: fail");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/adau_pkg.sv
sv/adau_lane.sv
sv/adau_merge.sv
sv/ascii_decimal_alu_unit.sv
tb/tb_top.sv
